// File: rtl/qrs_pkg.sv
package qrs_pkg;

	localparam int COEF_WIDTH     = 16;
	localparam int ROOT_FRAC_BITS = 16;
	localparam int ROOT_WIDTH     = 40;

	// root count codes
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_TWO  = 2'd2,
		KIND_INF  = 2'd3
	} kind_t;

endpackage

// File: rtl/qrs_if.sv
// coefficient channel
interface qrs_coef_if #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] coef_a;
	logic signed [COEF_WIDTH-1:0] coef_b;
	logic signed [COEF_WIDTH-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// result channel
interface qrs_root_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          root_kind;
	logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_one;
	logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_two;

	modport source (output valid, root_kind, root_one, root_two, input ready);
	modport sink   (input valid, root_kind, root_one, root_two, output ready);
endinterface

// File: rtl/quadratic_root_solver_unit.sv
// Quadratic root solver.
// Channel coef takes one set of Q8.8 coefficients a, b, c per transfer;
// channel root returns one result per set: a root count code and up to two
// roots in signed Q24.16 (absent roots read zero), in the order of input.
// The block is a pipeline: two stages form b*b - 4ac, then a row of
// COEF_WIDTH+1 square root cells (one root bit each), one stage builds the
// numerators and divisor, a row of COEF_WIDTH+1+ROOT_FRAC_BITS division
// cells (one quotient bit each, both roots side by side), and an output
// register. One set is accepted every cycle unless a stall at the root
// channel has filled every stage; the rate is set by the per-stage handshake,
// each cell passing its data to the next every cycle that the next can take it.
// Reset clears all valid flags; nothing is in flight afterwards.
// When the receiver stalls, items pack into empty stages behind the output
// register, and coef.ready drops only when every stage holds an item.
module quadratic_root_solver_unit #(
	parameter int COEF_WIDTH     = qrs_pkg::COEF_WIDTH,
	parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	qrs_coef_if.sink   coef,
	qrs_root_if.source root
);

	localparam int CW    = COEF_WIDTH;
	localparam int RW    = qrs_pkg::ROOT_WIDTH;
	localparam int RTW   = CW + 1;
	localparam int DW    = 2 * RTW;
	localparam int NW    = CW + 1 + ROOT_FRAC_BITS;
	localparam int DVW   = CW + 1;
	localparam int SQ_SW = 3 + 3 * CW;
	localparam int DV_SW = 4;
	localparam int EW    = ((NW > RW) ? NW : RW) + 1;

	// saturate a sign and magnitude quotient into the root width
	function automatic logic [RW-1:0] pack_root(input logic neg, input logic [NW-1:0] mag);
		logic [EW-1:0] ext;
		logic [EW-1:0] hi;
		logic [EW-1:0] neg_ext;
		ext     = EW'(mag);
		hi      = EW'({1'b0, {(RW-1){1'b1}}});
		neg_ext = -ext;
		if (!neg) begin
			pack_root = (ext > hi) ? hi[RW-1:0] : ext[RW-1:0];
		end else begin
			pack_root = (ext > hi + EW'(1)) ? {1'b1, {(RW-1){1'b0}}} : neg_ext[RW-1:0];
		end
	endfunction

	// stage 1: products
	logic                   v_s1;
	logic                   rdy_s1;
	logic signed [CW-1:0]   a_s1, b_s1, c_s1;
	logic signed [2*CW-1:0] bb_s1, ac_s1;
	logic signed [2*CW-1:0] bb_d, ac_d;

	// stage 2: discriminant and kind
	logic                   v_s2;
	logic                   rdy_s2;
	logic [DW-1:0]          rad_s2;
	logic [SQ_SW-1:0]       side_s2;
	logic signed [DW-1:0]   disc_d;
	qrs_pkg::kind_t         kind_d;
	logic                   lin_d;
	logic [DW-1:0]          rad_d;

	// square root row
	logic                   sq_v   [RTW+1];
	logic                   sq_r   [RTW+1];
	logic [DW-1:0]          sq_rad [RTW+1];
	logic [RTW+1:0]         sq_rem [RTW+1];
	logic [RTW-1:0]         sq_root[RTW+1];
	logic [SQ_SW-1:0]       sq_side[RTW+1];

	// stage 3: numerators and divisor
	logic                   v_s3;
	logic                   rdy_s3;
	logic [NW-1:0]          n1_s3, n2_s3;
	logic [DVW-1:0]         dm_s3;
	logic [DV_SW-1:0]       side_s3;
	logic                   lin_e;
	logic [1:0]             kind_e;
	logic signed [CW-1:0]   a_e, b_e, c_e;
	logic signed [CW+1:0]   nb, sv, n1, n2, dv;
	logic [CW+1:0]          m1, m2, md;

	// division row
	logic                   dv_v   [NW+1];
	logic                   dv_r   [NW+1];
	logic [NW-1:0]          dv_num [NW+1][2];
	logic [DVW-1:0]         dv_rem [NW+1][2];
	logic [NW-1:0]          dv_quo [NW+1][2];
	logic [DVW-1:0]         dv_den [NW+1];
	logic [DV_SW-1:0]       dv_side[NW+1];

	// output register
	logic                   vo_q;
	logic                   rdy_o;
	logic [1:0]             kind_q;
	logic [RW-1:0]          one_q, two_q;
	logic [1:0]             kind_f;
	logic [RW-1:0]          r1_f, r2_f;

	// ---------------- stage 1 ----------------
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign coef.ready = rdy_s1;
	assign bb_d       = (2*CW)'(coef.coef_b) * (2*CW)'(coef.coef_b);
	assign ac_d       = (2*CW)'(coef.coef_a) * (2*CW)'(coef.coef_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && coef.valid) begin
			a_s1  <= coef.coef_a;
			b_s1  <= coef.coef_b;
			c_s1  <= coef.coef_c;
			bb_s1 <= bb_d;
			ac_s1 <= ac_d;
		end
	end

	// ---------------- stage 2 ----------------
	assign rdy_s2 = !v_s2 || sq_r[0];
	assign disc_d = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
	assign lin_d  = (a_s1 == '0);

	always_comb begin
		kind_d = qrs_pkg::KIND_NONE;
		rad_d  = '0;
		if (lin_d) begin
			if (b_s1 != '0) begin
				kind_d = qrs_pkg::KIND_ONE;
			end else if (c_s1 == '0) begin
				kind_d = qrs_pkg::KIND_INF;
			end
		end else if (disc_d > 0) begin
			kind_d = qrs_pkg::KIND_TWO;
			rad_d  = disc_d;
		end else if (disc_d == '0) begin
			kind_d = qrs_pkg::KIND_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			rad_s2  <= rad_d;
			side_s2 <= {lin_d, kind_d, a_s1, b_s1, c_s1};
		end
	end

	// ---------------- square root row ----------------
	assign sq_v[0]    = v_s2;
	assign sq_rad[0]  = rad_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s2;

	for (genvar k = 0; k < RTW; k++) begin : g_sqrt
		qrs_sqrt_cell #(
			.RTW (RTW),
			.SW  (SQ_SW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_v[k]),
			.in_ready  (sq_r[k]),
			.in_rad    (sq_rad[k]),
			.in_rem    (sq_rem[k]),
			.in_root   (sq_root[k]),
			.in_side   (sq_side[k]),
			.out_valid (sq_v[k+1]),
			.out_ready (sq_r[k+1]),
			.out_rad   (sq_rad[k+1]),
			.out_rem   (sq_rem[k+1]),
			.out_root  (sq_root[k+1]),
			.out_side  (sq_side[k+1])
		);
	end

	assign sq_r[RTW] = rdy_s3;

	// ---------------- stage 3 ----------------
	assign rdy_s3 = !v_s3 || dv_r[0];
	assign {lin_e, kind_e, a_e, b_e, c_e} = sq_side[RTW];
	assign nb = -(CW+2)'(b_e);
	assign sv = $signed({1'b0, sq_root[RTW]});

	always_comb begin
		if (lin_e) begin
			n1 = -(CW+2)'(c_e);
			n2 = '0;
			dv = (CW+2)'(b_e);
		end else begin
			n1 = nb + sv;
			n2 = nb - sv;
			dv = (CW+2)'(a_e) <<< 1;
		end
		m1 = n1[CW+1] ? -n1 : n1;
		m2 = n2[CW+1] ? -n2 : n2;
		md = dv[CW+1] ? -dv : dv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= sq_v[RTW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && sq_v[RTW]) begin
			n1_s3   <= {m1[CW:0], {ROOT_FRAC_BITS{1'b0}}};
			n2_s3   <= {m2[CW:0], {ROOT_FRAC_BITS{1'b0}}};
			dm_s3   <= md[CW:0];
			side_s3 <= {kind_e, n1[CW+1] ^ dv[CW+1], n2[CW+1] ^ dv[CW+1]};
		end
	end

	// ---------------- division row ----------------
	assign dv_v[0]      = v_s3;
	assign dv_num[0][0] = n1_s3;
	assign dv_num[0][1] = n2_s3;
	assign dv_rem[0][0] = '0;
	assign dv_rem[0][1] = '0;
	assign dv_quo[0][0] = '0;
	assign dv_quo[0][1] = '0;
	assign dv_den[0]    = dm_s3;
	assign dv_side[0]   = side_s3;

	for (genvar k = 0; k < NW; k++) begin : g_div
		qrs_div_cell #(
			.NW  (NW),
			.DVW (DVW),
			.SW  (DV_SW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_v[k]),
			.in_ready  (dv_r[k]),
			.in_num    (dv_num[k]),
			.in_rem    (dv_rem[k]),
			.in_quo    (dv_quo[k]),
			.in_den    (dv_den[k]),
			.in_side   (dv_side[k]),
			.out_valid (dv_v[k+1]),
			.out_ready (dv_r[k+1]),
			.out_num   (dv_num[k+1]),
			.out_rem   (dv_rem[k+1]),
			.out_quo   (dv_quo[k+1]),
			.out_den   (dv_den[k+1]),
			.out_side  (dv_side[k+1])
		);
	end

	assign dv_r[NW] = rdy_o;

	// ---------------- output register ----------------
	assign rdy_o  = !vo_q || root.ready;
	assign kind_f = dv_side[NW][3:2];

	always_comb begin
		r1_f = '0;
		r2_f = '0;
		case (kind_f)
			qrs_pkg::KIND_TWO: begin
				r1_f = pack_root(dv_side[NW][1], dv_quo[NW][0]);
				r2_f = pack_root(dv_side[NW][0], dv_quo[NW][1]);
			end
			qrs_pkg::KIND_ONE: begin
				r1_f = pack_root(dv_side[NW][1], dv_quo[NW][0]);
			end
			default: begin
				r1_f = '0;
				r2_f = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (rdy_o) begin
			vo_q <= dv_v[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && dv_v[NW]) begin
			kind_q <= kind_f;
			one_q  <= r1_f;
			two_q  <= r2_f;
		end
	end

	assign root.valid     = vo_q;
	assign root.root_kind = kind_q;
	assign root.root_one  = one_q;
	assign root.root_two  = two_q;

endmodule

// File: rtl/qrs_sqrt_cell.sv
// One digit of the integer square root: takes two radicand bits, yields one root bit.
module qrs_sqrt_cell #(
	parameter int RTW = qrs_pkg::COEF_WIDTH + 1,
	parameter int SW  = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2*RTW-1:0] in_rad,
	input  logic [RTW+1:0]   in_rem,
	input  logic [RTW-1:0]   in_root,
	input  logic [SW-1:0]    in_side,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2*RTW-1:0] out_rad,
	output logic [RTW+1:0]   out_rem,
	output logic [RTW-1:0]   out_root,
	output logic [SW-1:0]    out_side
);

	logic             valid_q;
	logic [2*RTW-1:0] rad_q;
	logic [RTW+1:0]   rem_q;
	logic [RTW-1:0]   root_q;
	logic [SW-1:0]    side_q;

	logic [RTW+3:0]   cand;
	logic [RTW+3:0]   trial;
	logic [RTW+3:0]   diff;
	logic             take;

	// trial subtraction
	assign cand  = {in_rem, in_rad[2*RTW-1 -: 2]};
	assign trial = {2'b00, in_root, 2'b01};
	assign diff  = cand - trial;
	assign take  = (cand >= trial);

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rad_q  <= {in_rad[2*RTW-3:0], 2'b00};
			rem_q  <= take ? diff[RTW+1:0] : cand[RTW+1:0];
			root_q <= {in_root[RTW-2:0], take};
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rad   = rad_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;
	assign out_side  = side_q;

endmodule

// File: rtl/qrs_div_cell.sv
// One quotient bit of a restoring division, two lanes sharing one divisor.
module qrs_div_cell #(
	parameter int NW  = 33,
	parameter int DVW = 17,
	parameter int SW  = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [NW-1:0]  in_num [2],
	input  logic [DVW-1:0] in_rem [2],
	input  logic [NW-1:0]  in_quo [2],
	input  logic [DVW-1:0] in_den,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [NW-1:0]  out_num [2],
	output logic [DVW-1:0] out_rem [2],
	output logic [NW-1:0]  out_quo [2],
	output logic [DVW-1:0] out_den,
	output logic [SW-1:0]  out_side
);

	logic           valid_q;
	logic [NW-1:0]  num_q [2];
	logic [DVW-1:0] rem_q [2];
	logic [NW-1:0]  quo_q [2];
	logic [DVW-1:0] den_q;
	logic [SW-1:0]  side_q;

	logic [DVW:0]   cand [2];
	logic [DVW:0]   diff [2];
	logic           take [2];

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		// shift in next dividend bit, subtract if it fits
		assign cand[l] = {in_rem[l], in_num[l][NW-1]};
		assign diff[l] = cand[l] - {1'b0, in_den};
		assign take[l] = (cand[l] >= {1'b0, in_den});

		always_ff @(posedge clk) begin
			if (in_ready && in_valid) begin
				num_q[l] <= {in_num[l][NW-2:0], 1'b0};
				rem_q[l] <= take[l] ? diff[l][DVW-1:0] : cand[l][DVW-1:0];
				quo_q[l] <= {in_quo[l][NW-2:0], take[l]};
			end
		end

		assign out_num[l] = num_q[l];
		assign out_rem[l] = rem_q[l];
		assign out_quo[l] = quo_q[l];
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			den_q  <= in_den;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_den   = den_q;
	assign out_side  = side_q;

endmodule

// File: rtl/qrs_checker.sv
// Port-level checks on the solver.
module qrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    root_kind,
	input logic [qrs_pkg::ROOT_WIDTH-1:0] root_one,
	input logic [qrs_pkg::ROOT_WIDTH-1:0] root_two
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// nothing comes out right after reset
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result right after reset");

	// no roots or infinitely many: both roots read zero
	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_kind == qrs_pkg::KIND_NONE || root_kind == qrs_pkg::KIND_INF)
		|-> root_one == '0 && root_two == '0)
		else $error("absent roots not zero");

	// a single root leaves the second slot empty
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == qrs_pkg::KIND_ONE |-> root_two == '0)
		else $error("second root set for single root");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (root.valid),
	.out_ready (root.ready),
	.root_kind (root.root_kind),
	.root_one  (root.root_one),
	.root_two  (root.root_two)
);
